@@ sv/min_priority_queue_assert.svh @@
// ----------------------------------------------------------------------------
// min_priority_queue_assert.svh
// Assertion macros used by the priority queue RTL
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define MPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition that must never be true outside reset
`define MPQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define MPQ_ASSERT(label, clk, rst_n, prop)
`define MPQ_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ sv/mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mpq_pkg
// Types, widths and codes of the min priority queue
// ----------------------------------------------------------------------------
package mpq_pkg;

    // storage size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

    // command broadcast to every cell of the sorted chain
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] val;
    } t_cell_cmd;

endpackage

@@ sv/mpq_in_if.sv @@
// ----------------------------------------------------------------------------
// mpq_in_if
// Request channel: operation and value with valid/ready
// ----------------------------------------------------------------------------
interface mpq_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [mpq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ sv/mpq_out_if.sv @@
// ----------------------------------------------------------------------------
// mpq_out_if
// Result channel: removed value, status and occupancy with valid/ready
// ----------------------------------------------------------------------------
interface mpq_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mpq_pkg::VALUE_W-1:0]  removed_value;
    logic        [mpq_pkg::STATUS_W-1:0] status;
    logic        [mpq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output removed_value, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input occupancy, output ready);
endinterface

@@ sv/mpq_cell.sv @@
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds, takes the new value or shifts
// ----------------------------------------------------------------------------
module mpq_cell (
    input  logic                               i_clk,
    input  mpq_pkg::t_cell_cmd                 i_cmd,
    input  logic                               i_occupied,
    input  logic                               i_left_keep,
    input  logic signed [mpq_pkg::VALUE_W-1:0] i_left_val,
    input  logic signed [mpq_pkg::VALUE_W-1:0] i_right_val,
    output logic                               o_keep,
    output logic signed [mpq_pkg::VALUE_W-1:0] o_val
);

    logic signed [mpq_pkg::VALUE_W-1:0] r_val;
    logic signed [mpq_pkg::VALUE_W-1:0] n_val;

    // an occupied cell not above the new value stays put, so equal values
    // keep their arrival order
    assign o_keep = i_occupied && (r_val <= i_cmd.val);
    assign o_val  = r_val;

    // next value: shift toward head on remove, open a gap on insert
    always_comb begin
        n_val = r_val;
        if (i_cmd.rem) begin
            n_val = i_right_val;
        end else if (i_cmd.ins && !o_keep) begin
            n_val = i_left_keep ? i_cmd.val : i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ sv/min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// min_priority_queue
// Bounded ascending priority queue built as a sorted chain of cells
// ----------------------------------------------------------------------------
// channel  dir  payload                                  transfer when
// i_in     in   operation, value                         valid && ready
// o_out    out  removed_value, status, occupancy         valid && ready
//
// On each request all cells compare against the new value in parallel and
// shift in the same clock, so one transfer per cycle is kept up while the
// result side takes results. The result is registered; a new request is taken
// while the result register is empty or is being drained in the same cycle.
// Synchronous active-low reset empties the queue and the result register;
// the cell contents are not cleared, only the entry count.
// ----------------------------------------------------------------------------
`include "min_priority_queue_assert.svh"

module min_priority_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpq_in_if.sink    i_in,
    mpq_out_if.source o_out
);

    localparam int N = mpq_pkg::CAPACITY;

    logic [mpq_pkg::CNT_W-1:0] r_count;
    logic [mpq_pkg::CNT_W-1:0] n_count;

    logic                                r_out_valid;
    logic signed [mpq_pkg::VALUE_W-1:0]  r_removed;
    logic        [mpq_pkg::STATUS_W-1:0] r_status;
    logic        [mpq_pkg::OCC_W-1:0]    r_occ;

    logic signed [mpq_pkg::VALUE_W-1:0]  n_removed;
    logic        [mpq_pkg::STATUS_W-1:0] n_status;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    mpq_pkg::t_cell_cmd w_cmd;

    logic                               w_keep [N];
    logic signed [mpq_pkg::VALUE_W-1:0] w_val  [N];

    // request handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == mpq_pkg::CNT_W'(N));
    assign w_empty    = (r_count == '0);

    // command to the chain
    assign w_cmd.ins = w_accept && (i_in.operation == mpq_pkg::OP_INSERT) && !w_full;
    assign w_cmd.rem = w_accept && (i_in.operation == mpq_pkg::OP_REMOVE) && !w_empty;
    assign w_cmd.val = i_in.value;

    // sorted chain, head at cell 0
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic                               w_left_keep;
        logic signed [mpq_pkg::VALUE_W-1:0] w_left_val;
        logic signed [mpq_pkg::VALUE_W-1:0] w_right_val;

        if (g == 0) begin : g_head
            assign w_left_keep = 1'b1;
            assign w_left_val  = i_in.value;
        end else begin : g_body
            assign w_left_keep = w_keep[g-1];
            assign w_left_val  = w_val[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_right_val = '0;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occupied  (r_count > mpq_pkg::CNT_W'(g)),
            .i_left_keep (w_left_keep),
            .i_left_val  (w_left_val),
            .i_right_val (w_right_val),
            .o_keep      (w_keep[g]),
            .o_val       (w_val[g])
        );
    end

    // result and next count
    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        n_status  = mpq_pkg::ST_INSERTED;
        unique case (i_in.operation)
            mpq_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = mpq_pkg::ST_OVERFLOW;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            mpq_pkg::OP_REMOVE: begin
                if (w_empty) begin
                    n_status = mpq_pkg::ST_UNDERFLOW;
                end else begin
                    n_status  = mpq_pkg::ST_REMOVED;
                    n_removed = w_val[0];
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                n_status = mpq_pkg::ST_INSERTED;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_occ     <= mpq_pkg::OCC_W'(n_count);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_removed;
    assign o_out.status        = r_status;
    assign o_out.occupancy     = r_occ;

    // checks
    `MPQ_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > mpq_pkg::CNT_W'(N))
    `MPQ_ASSERT(a_insert_grows, i_clk, i_rst_n, w_cmd.ins |=> r_count == $past(r_count) + 1'b1)
    `MPQ_ASSERT(a_remove_shrinks, i_clk, i_rst_n, w_cmd.rem |=> r_count == $past(r_count) - 1'b1)
    `MPQ_ASSERT(a_underflow_flag, i_clk, i_rst_n, (w_accept && w_empty && i_in.operation == mpq_pkg::OP_REMOVE) |=> (r_status == mpq_pkg::ST_UNDERFLOW && r_count == '0))
    `MPQ_ASSERT_NEVER(a_both_cmds, i_clk, i_rst_n, w_cmd.ins && w_cmd.rem)

endmodule

@@ dv/mpq_result_checker.sv @@
// ----------------------------------------------------------------------------
// mpq_result_checker
// Watches both channels of the min priority queue, predicts every result from
// a shadow copy of the store and compares each result transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpq_result_checker
    import mpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mpq_in_if    i_req,
    mpq_out_if   i_rsp,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked,
    output int   o_overflows,
    output int   o_underflows
);

    typedef struct packed {
        logic signed [VALUE_W-1:0]  removed_value;
        logic        [STATUS_W-1:0] status;
        logic        [OCC_W-1:0]    occupancy;
    } t_queue_result;

    // shadow store in insertion order, and results still owed by the block
    logic signed [VALUE_W-1:0] shadow_store[$];
    t_queue_result             owed_results[$];

    // apply one request to the shadow store and return the result it gives
    function automatic t_queue_result apply_request(input logic op,
                                                    input logic signed [VALUE_W-1:0] val);
        t_queue_result res;
        int            pick;
        res.removed_value = '0;
        if (op == OP_INSERT) begin
            if (shadow_store.size() >= CAPACITY) begin
                res.status = ST_OVERFLOW;
            end else begin
                shadow_store.push_back(val);
                res.status = ST_INSERTED;
            end
        end else if (shadow_store.size() == 0) begin
            res.status = ST_UNDERFLOW;
        end else begin
            // strict less-than keeps the earliest entry among equal minima
            pick = 0;
            for (int i = 1; i < shadow_store.size(); i++) begin
                if (shadow_store[i] < shadow_store[pick]) begin
                    pick = i;
                end
            end
            res.removed_value = shadow_store[pick];
            shadow_store.delete(pick);
            res.status = ST_REMOVED;
        end
        res.occupancy = OCC_W'(shadow_store.size());
        return res;
    endfunction

    // one line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        o_mismatches++;
    endtask

    // compare the result transfer first: results are registered, so a result
    // never belongs to a request taken at the same edge
    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            shadow_store.delete();
            owed_results.delete();
            o_mismatches = 0;
            o_pending    = 0;
            o_checked    = 0;
            o_overflows  = 0;
            o_underflows = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with no request outstanding: status %0d value %0d occupancy %0d",
                        i_rsp.status, i_rsp.removed_value, i_rsp.occupancy));
                end else begin
                    want = owed_results.pop_front();
                    if (i_rsp.removed_value !== want.removed_value) begin
                        report_mismatch($sformatf("result %0d removed_value %0d, expected %0d",
                                                  o_checked, i_rsp.removed_value,
                                                  want.removed_value));
                    end
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  o_checked, i_rsp.status, want.status));
                    end
                    if (i_rsp.occupancy !== want.occupancy) begin
                        report_mismatch($sformatf("result %0d occupancy %0d, expected %0d",
                                                  o_checked, i_rsp.occupancy,
                                                  want.occupancy));
                    end
                    if (want.status == ST_OVERFLOW) begin
                        o_overflows++;
                    end
                    if (want.status == ST_UNDERFLOW) begin
                        o_underflows++;
                    end
                    o_checked++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                owed_results.push_back(apply_request(i_req.operation, i_req.value));
            end
            o_pending = owed_results.size();
        end
    end

endmodule

@@ dv/min_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// min_priority_queue_tb
// Drives corner-case requests, then random insert/remove bursts of varying
// mix with random idles on both channels, a long output hold-off with an
// insert-heavy burst that fills the queue, and drain pauses; the checker
// predicts and compares every result
`timescale 1ns / 1ps

module min_priority_queue_tb;
    import mpq_pkg::*;

    localparam int ITEMS        = 1450;
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 20;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // corner values filling the queue once in the directed part
    localparam logic signed [VALUE_W-1:0] CORNER_VALUES [16] = '{
        VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA,
        32'sd7, 32'sd7, -32'sd7, VAL_MIN + 32'sd1, VAL_MAX - 32'sd1, 32'sd3,
        -32'sd1, 32'sd100, 32'sd0
    };

    logic clk;
    logic rst_n;

    mpq_in_if  req_ch();
    mpq_out_if rsp_ch();

    int mismatches;
    int pending;
    int checked;
    int overflows;
    int underflows;

    int cycles;
    int requests_sent;
    bit src_gaps_on;
    bit sink_stalls_on;
    bit hold_off_req;

    min_priority_queue DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    mpq_result_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_overflows  (overflows),
        .o_underflows (underflows)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("TIMEOUT after %0d cycles, %0d results still owed", cycles, pending);
        $display("Test completed with failures");
        $finish;
    end

    // idle length: mostly short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned source_gap();
        if (src_gaps_on && $urandom_range(0, 99) < 30) begin
            return idle_len();
        end
        return 0;
    endfunction

    function automatic logic random_op(input int unsigned ins_pct);
        return ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
    endfunction

    // full range, a narrow band for ties, a moderate band and the extremes
    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return $urandom;
        end else if (r < 70) begin
            return int'($urandom_range(0, 16)) - 8;
        end else if (r < 90) begin
            return int'($urandom_range(0, 2000)) - 1000;
        end
        case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return VAL_MIN + 32'sd1;
            default: return VAL_MAX - 32'sd1;
        endcase
    endfunction

    // present one request and wait for its transfer; starts and ends at a
    // falling edge, valid stays high so back-to-back requests need no toggle
    task automatic send_request(input logic op, input logic signed [VALUE_W-1:0] val,
                                input int unsigned gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        requests_sent++;
    endtask

    // stop offering and wait until every owed result has arrived
    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // result side: random stalls, stall-free stretches, one long hold-off
    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                stall_left   = HOLD_CYCLES - 1;
            end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
                rsp_ch.ready <= 1'b0;
                stall_left   = idle_len() - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int          burst_no;
        int unsigned burst_len;
        int unsigned ins_pct;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.value     = '0;
        rst_n            = 1'b0;
        requests_sent    = 0;
        src_gaps_on      = 1'b1;
        sink_stalls_on   = 1'b1;
        hold_off_req     = 1'b0;
        burst_no         = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: remove from empty, fill with corners, overflow, removes
        send_request(OP_REMOVE, 32'sh1234_5678, 0);
        foreach (CORNER_VALUES[i]) begin
            send_request(OP_INSERT, CORNER_VALUES[i], source_gap());
        end
        send_request(OP_INSERT, -32'sd50, 0);
        repeat (4) send_request(OP_REMOVE, random_value(), source_gap());
        pause_until_drained();

        // random bursts with a changing insert/remove mix
        while (requests_sent < ITEMS) begin
            burst_no++;
            burst_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       ins_pct = 15;
                1:       ins_pct = 50;
                default: ins_pct = 85;
            endcase
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            if (burst_no == 3) begin
                // result side holds off, which also stalls requests; mostly inserts fill the queue
                hold_off_req = 1'b1;
                ins_pct      = 95;
                burst_len    = 50;
                src_gaps_on  = 1'b0;
            end
            if (burst_no == 8 || $urandom_range(0, 9) == 0) begin
                pause_until_drained();
            end
            for (int k = 0; k < burst_len && requests_sent < ITEMS; k++) begin
                send_request(random_op(ins_pct), random_value(), source_gap());
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d checked results, %0d overflows, %0d underflows",
                 requests_sent, checked, overflows, underflows);
        $display("including a %0d-cycle result hold-off against a full queue and drain pauses",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
